/* sv/hex_string_decoder_assert.svh */
// ----------------------------------------------------------------------------
// hex_string_decoder_assert.svh
// Assertion macros used by the checker module of the hex string decoder.
// ----------------------------------------------------------------------------
`ifndef HEX_STRING_DECODER_ASSERT_SVH
`define HEX_STRING_DECODER_ASSERT_SVH

// assert on clk, masked while rst_n is low
`define HSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hex_string_decoder assertion failed");

// assert on clk, also checked through reset
`define HSD_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("hex_string_decoder reset assertion failed");

`endif

/* sv/hsd_pkg.sv */
// ----------------------------------------------------------------------------
// hsd_pkg
// Types, constants and the character decode shared by the hex string decoder.
// ----------------------------------------------------------------------------
package hsd_pkg;

  localparam int CHAR_W          = 8;
  localparam int CAP_W           = 16;
  localparam int BYTE_COUNT_W    = 16;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_INDEX_W     = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LEFT_PAD = 1'b0,
    CFG_OUT_CAP  = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FORMAT   = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic                    ok;
    logic [3:0]              value;
  } hex_t;

  typedef struct packed {
    logic [BYTE_COUNT_W-1:0] byte_count;
    status_t                 status;
    logic                    done_res;
    logic                    byte_valid;
    logic [7:0]              byte_value;
  } result_t;

  function automatic hex_t hex_decode(input logic [CHAR_W-1:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.value = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

/* sv/hsd_core.sv */
// ----------------------------------------------------------------------------
// hsd_core
// Configuration registers, string state and the per-character decode step.
// ----------------------------------------------------------------------------
module hsd_core #(
  parameter int COUNT_WIDTH = hsd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  hsd_pkg::cfg_index_t            cfg_index,
  input  logic [hsd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           acc,
  input  logic [hsd_pkg::CHAR_W-1:0]     char_code,
  input  logic                           odd_length,
  input  logic                           last_char,
  output logic                           res_valid,
  output hsd_pkg::result_t               res
);

  localparam int CMP_W = (COUNT_WIDTH > hsd_pkg::BYTE_COUNT_W) ? COUNT_WIDTH
                                                                : hsd_pkg::BYTE_COUNT_W;

  logic                      left_pad_r;
  logic [hsd_pkg::CAP_W-1:0] out_capacity_r;
  logic [3:0]                high_nibble_r, high_nibble_nxt;
  logic                      have_high_r, have_high_nxt;
  logic                      at_start_r, at_start_nxt;
  logic                      aborted_r, aborted_nxt;
  logic [COUNT_WIDTH-1:0]    bytes_made_r, bytes_made_nxt;

  hsd_pkg::hex_t             hex;
  logic                      full;
  logic                      emit;
  logic [7:0]                byte_v;
  logic [CMP_W-1:0]          cnt_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_pad_r     <= 1'b1;
      out_capacity_r <= '1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        hsd_pkg::CFG_LEFT_PAD: left_pad_r     <= cfg_data[0];
        hsd_pkg::CFG_OUT_CAP:  out_capacity_r <= cfg_data[hsd_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    hex  = hsd_pkg::hex_decode(char_code);
    full = (CMP_W'(bytes_made_r) >= CMP_W'(out_capacity_r)) || (&bytes_made_r);

    high_nibble_nxt = high_nibble_r;
    have_high_nxt   = have_high_r;
    at_start_nxt    = at_start_r;
    aborted_nxt     = aborted_r;
    bytes_made_nxt  = bytes_made_r;
    emit            = 1'b0;
    byte_v          = 8'd0;
    res_valid       = 1'b0;
    res             = '0;
    cnt_ext         = CMP_W'(bytes_made_r);

    if (acc) begin
      if (aborted_r) begin
        if (last_char) begin
          high_nibble_nxt = 4'd0;
          have_high_nxt   = 1'b0;
          at_start_nxt    = 1'b1;
          aborted_nxt     = 1'b0;
          bytes_made_nxt  = '0;
        end
      end else if ((!have_high_r && full) || !hex.ok) begin
        res_valid    = 1'b1;
        res.done_res = 1'b1;
        res.status   = (!have_high_r && full) ? hsd_pkg::ST_OVERFLOW : hsd_pkg::ST_FORMAT;
        if (last_char) begin
          high_nibble_nxt = 4'd0;
          have_high_nxt   = 1'b0;
          at_start_nxt    = 1'b1;
          bytes_made_nxt  = '0;
        end else begin
          aborted_nxt = 1'b1;
        end
      end else begin
        if (have_high_r) begin
          byte_v        = {high_nibble_r, hex.value};
          have_high_nxt = 1'b0;
          emit          = 1'b1;
        end else if (at_start_r && left_pad_r && odd_length) begin
          byte_v = {4'd0, hex.value};
          emit   = 1'b1;
        end else if (last_char) begin
          byte_v = {hex.value, 4'd0};
          emit   = 1'b1;
        end else begin
          high_nibble_nxt = hex.value;
          have_high_nxt   = 1'b1;
        end
        at_start_nxt = 1'b0;
        if (emit) begin
          bytes_made_nxt = bytes_made_r + COUNT_WIDTH'(1);
          cnt_ext        = CMP_W'(bytes_made_nxt);
        end
        res_valid      = emit || last_char;
        res.byte_value = byte_v;
        res.byte_valid = emit;
        res.done_res   = last_char;
        res.status     = hsd_pkg::ST_OK;
        if (last_char) begin
          high_nibble_nxt = 4'd0;
          have_high_nxt   = 1'b0;
          at_start_nxt    = 1'b1;
          bytes_made_nxt  = '0;
        end
      end
    end
    res.byte_count = cnt_ext[hsd_pkg::BYTE_COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_nibble_r <= 4'd0;
      have_high_r   <= 1'b0;
      at_start_r    <= 1'b1;
      aborted_r     <= 1'b0;
      bytes_made_r  <= '0;
    end else begin
      high_nibble_r <= high_nibble_nxt;
      have_high_r   <= have_high_nxt;
      at_start_r    <= at_start_nxt;
      aborted_r     <= aborted_nxt;
      bytes_made_r  <= bytes_made_nxt;
    end
  end

endmodule

/* sv/hsd_skid.sv */
// ----------------------------------------------------------------------------
// hsd_skid
// Output register with a skid stage so that results survive a stalled sink.
// ----------------------------------------------------------------------------
module hsd_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hsd_pkg::result_t push_data,
  output logic             push_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output hsd_pkg::result_t out_data
);

  logic             out_valid_r;
  hsd_pkg::result_t out_data_r;
  logic             skid_valid_r;
  hsd_pkg::result_t skid_data_r;
  logic             load_out;

  assign load_out   = !out_valid_r || out_ready;
  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (load_out) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end
    if (!load_out && push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

/* sv/hex_string_decoder.sv */
// ----------------------------------------------------------------------------
// hex_string_decoder
// ASCII hex characters in, decoded bytes and per-string status out.
// ----------------------------------------------------------------------------
// One character enters per beat on the in_ channel: in_tdata is the character,
// in_tuser the odd-length flag (read on the first character of a string) and
// in_tlast marks the final character. A beat on the out_ channel carries a
// decoded byte, the running byte count and, with out_tlast, the end of the
// string and its status (success, format error, overflow). After an error the
// rest of the string is swallowed up to its last character.
// Throughput is one character per cycle while in_tready is high. Decode and
// nibble merge are done in the accepting cycle; each result is registered in
// the output register, or in the skid stage if the sink stalls; together they
// hold two results at most; in_tready drops only while the skid stage is
// occupied, so a sink stall backs up the input after one further result.
// Synchronous reset empties both stages, restores left_pad to 1 and the
// capacity to 65535, and readies the block for a new string.
// The configuration port takes a write in any cycle with cfg_wr_en high.
// ----------------------------------------------------------------------------
module hex_string_decoder #(
  parameter int COUNT_WIDTH = hsd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [hsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hsd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // char_code
  input  logic                            in_tuser,   // odd_length
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata,  // byte_value, byte_count
  output logic [2:0]                      out_tuser,  // byte_valid, status
  output logic                            out_tlast
);

  logic             acc;
  logic             res_valid;
  hsd_pkg::result_t res;
  hsd_pkg::result_t out_res;

  assign acc = in_tvalid && in_tready;

  hsd_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (hsd_pkg::cfg_index_t'(cfg_index)),
    .cfg_data   (cfg_data),
    .acc        (acc),
    .char_code  (in_tdata),
    .odd_length (in_tuser),
    .last_char  (in_tlast),
    .res_valid  (res_valid),
    .res        (res)
  );

  hsd_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = {out_res.byte_count, out_res.byte_value};
  assign out_tuser = {out_res.status, out_res.byte_valid};
  assign out_tlast = out_res.done_res;

endmodule

/* sv/hsd_checker.sv */
// ----------------------------------------------------------------------------
// hsd_checker
// Port-level checks on the hex string decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "hex_string_decoder_assert.svh"

module hsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  `HSD_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
  `HSD_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid && in_tready)
  `HSD_ASSERT(a_ready_when_idle, !out_tvalid |-> in_tready)
  `HSD_ASSERT(a_no_byte_zero, out_tvalid && !out_tuser[0] |-> out_tdata[7:0] == 8'd0)
  `HSD_ASSERT(a_status_at_end, out_tvalid && !out_tlast |-> out_tuser[2:1] == 2'd0 && out_tuser[0])

endmodule

bind hex_string_decoder hsd_checker u_hsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
